@@ src/rhs_upd_pkg.sv @@
// Shared types, command codes and arithmetic helpers for the scenario RHS update block.
`timescale 1ns / 1ps
package rhs_upd_pkg;

  localparam int unsigned ActW  = 4;
  localparam int unsigned RowW  = 11;
  localparam int unsigned ColW  = 10;
  localparam int unsigned DataW = 32;
  // Sweep counter width: holds any row or column count up to 1024.
  localparam int unsigned CntW  = 11;

  localparam logic [ActW-1:0] ActLoadRhs   = 4'd0;
  localparam logic [ActW-1:0] ActLoadCost  = 4'd1;
  localparam logic [ActW-1:0] ActLoadTrial = 4'd2;
  localparam logic [ActW-1:0] ActClear     = 4'd3;
  localparam logic [ActW-1:0] ActBaseNz    = 4'd4;
  localparam logic [ActW-1:0] ActBegin     = 4'd5;
  localparam logic [ActW-1:0] ActRhsDelta  = 4'd6;
  localparam logic [ActW-1:0] ActMatDelta  = 4'd7;
  localparam logic [ActW-1:0] ActCostDelta = 4'd8;
  localparam logic [ActW-1:0] ActFinish    = 4'd9;
  localparam logic [ActW-1:0] ActRead      = 4'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load_item;  // capture the accepted item
    logic            wr_simple;  // plain store for loads and the cost delta
    logic            rd_rmw;     // read trial and the target entry
    logic            mul_en;     // form value times trial
    logic            rnd_en;     // form the addend: rounded, saturated product, or the rhs delta value
    logic            acc_wr;     // write back the saturated sum
    logic            rd_out;     // read for a result
    logic            clr_wr;     // clear one product entry
    logic            beg_rd;     // copy sweep, read side
    logic            fin_rd;     // finish sweep, read side
    logic [CntW-1:0] sweep_addr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [ActW-1:0] action;
    logic            row_ok;
    logic            trial_ok;
  } status_t;

  function automatic logic signed [DataW-1:0] sat_add(
    input logic signed [DataW-1:0] a,
    input logic signed [DataW-1:0] b,
    input logic                    sub
  );
    logic signed [DataW:0] s;
    logic signed [DataW:0] bx;
    bx = sub ? -{b[DataW-1], b} : {b[DataW-1], b};
    s  = {a[DataW-1], a} + bx;
    if (s[DataW] != s[DataW-1]) begin
      sat_add = s[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      sat_add = s[DataW-1:0];
    end
  endfunction

  // Round a Q31.32 product to Q15.16, ties toward plus infinity, then saturate.
  function automatic logic signed [DataW-1:0] round_sat(input logic signed [63:0] p);
    logic signed [63:0] rs;
    logic        [47:0] r;
    rs = p + 64'sd32768;
    r  = rs[63:16];
    if (r[47:31] != {17{1'b0}} && r[47:31] != {17{1'b1}}) begin
      round_sat = r[47] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    end else begin
      round_sat = r[31:0];
    end
  endfunction

endpackage

@@ src/rhs_upd_ctrl.sv @@
// Controller state machine that sequences commands, sweeps and the multiply path.
`timescale 1ns / 1ps
module rhs_upd_ctrl #(
  parameter int unsigned ROWS    = 1024,
  parameter int unsigned SWEEP_N = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  rhs_upd_pkg::status_t st_i,
  output rhs_upd_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_EXEC   = 4'd2;
  localparam logic [3:0] S_MUL    = 4'd3;
  localparam logic [3:0] S_RND    = 4'd4;
  localparam logic [3:0] S_ACC    = 4'd5;
  localparam logic [3:0] S_BEGIN  = 4'd6;
  localparam logic [3:0] S_FINISH = 4'd7;
  localparam logic [3:0] S_DRAIN  = 4'd8;

  localparam logic [rhs_upd_pkg::CntW-1:0] RowLast   = rhs_upd_pkg::CntW'(ROWS - 1);
  localparam logic [rhs_upd_pkg::CntW-1:0] SweepLast = rhs_upd_pkg::CntW'(SWEEP_N - 1);

  logic [3:0]                   state_q, state_d;
  logic [rhs_upd_pkg::CntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    cmd_o            = '0;
    cmd_o.sweep_addr = cnt_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == RowLast) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        cnt_d   = '0;
        case (st_i.action)
          rhs_upd_pkg::ActLoadRhs, rhs_upd_pkg::ActLoadCost,
          rhs_upd_pkg::ActLoadTrial, rhs_upd_pkg::ActCostDelta: begin
            cmd_o.wr_simple = 1'b1;
          end
          rhs_upd_pkg::ActClear: begin
            state_d = S_CLEAR;
          end
          rhs_upd_pkg::ActBaseNz, rhs_upd_pkg::ActMatDelta: begin
            if (st_i.row_ok && st_i.trial_ok) begin
              cmd_o.rd_rmw = 1'b1;
              state_d      = S_MUL;
            end
          end
          rhs_upd_pkg::ActRhsDelta: begin
            if (st_i.row_ok) begin
              cmd_o.rd_rmw = 1'b1;
              state_d      = S_RND;
            end
          end
          rhs_upd_pkg::ActBegin: begin
            state_d = S_BEGIN;
          end
          rhs_upd_pkg::ActFinish: begin
            state_d = S_FINISH;
          end
          rhs_upd_pkg::ActRead: begin
            cmd_o.rd_out = 1'b1;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_RND;
      end
      S_RND: begin
        cmd_o.rnd_en = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_BEGIN: begin
        cmd_o.beg_rd = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == SweepLast) begin
          state_d = S_DRAIN;
        end
      end
      S_FINISH: begin
        cmd_o.fin_rd = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == RowLast) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

@@ src/rhs_upd_dp.sv @@
// Datapath with the vector memories, the multiplier and the saturating adder.
`timescale 1ns / 1ps
module rhs_upd_dp #(
  parameter int unsigned ROWS       = 1024,
  parameter int unsigned COLS       = 1024,
  parameter int unsigned FIRST_COLS = 256
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic [rhs_upd_pkg::ActW-1:0]            action_i,
  input  logic [rhs_upd_pkg::RowW-1:0]            row_index_i,
  input  logic [rhs_upd_pkg::ColW-1:0]            col_index_i,
  input  logic signed [rhs_upd_pkg::DataW-1:0]    value_i,
  input  rhs_upd_pkg::cmd_t                       cmd_i,
  output rhs_upd_pkg::status_t                    st_o,
  output logic                                    read_valid_o,
  output logic signed [rhs_upd_pkg::DataW-1:0]    read_value_o
);

  localparam int unsigned RAW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CAW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned TAW = (FIRST_COLS > 1) ? $clog2(FIRST_COLS) : 1;
  localparam int unsigned DW  = rhs_upd_pkg::DataW;
  localparam int unsigned NW  = rhs_upd_pkg::CntW;

  logic [DW-1:0] rhs_base_m  [ROWS];
  logic [DW-1:0] rhs_work_m  [ROWS];
  logic [DW-1:0] prod_m      [ROWS];
  logic [DW-1:0] cost_base_m [COLS];
  logic [DW-1:0] cost_work_m [COLS];
  logic [DW-1:0] trial_m     [FIRST_COLS];

  logic [rhs_upd_pkg::ActW-1:0] act_q;
  logic [rhs_upd_pkg::RowW-1:0] row_q;
  logic [rhs_upd_pkg::ColW-1:0] col_q;
  logic signed [DW-1:0]         value_q;

  logic signed [DW-1:0] rhs_base_rd_q, rhs_work_rd_q, prod_rd_q;
  logic signed [DW-1:0] cost_base_rd_q, cost_work_rd_q, trial_rd_q;
  logic signed [63:0]   mul_q;
  logic signed [DW-1:0] addend_q;

  logic          beg_v_q, fin_v_q, read_valid_q;
  logic [NW-1:0] wb_addr_q;
  logic [1:0]    out_sel_q;

  logic          row_ok, cost_ok, trial_ok, cost_rd_ok;
  logic [NW-1:0] cost_k;
  logic          wb_row_ok, wb_col_ok, sw_row_ok, sw_col_ok;
  logic signed [DW-1:0] acc_sum;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      act_q   <= action_i;
      row_q   <= row_index_i;
      col_q   <= col_index_i;
      value_q <= value_i;
    end
  end

  assign row_ok     = row_q < NW'(ROWS);
  assign cost_ok    = {1'b0, col_q} < NW'(COLS);
  assign trial_ok   = {1'b0, col_q} < NW'(FIRST_COLS);
  assign cost_k     = row_q - NW'(ROWS);
  assign cost_rd_ok = !row_ok && (cost_k < NW'(COLS));
  assign sw_row_ok  = cmd_i.sweep_addr < NW'(ROWS);
  assign sw_col_ok  = cmd_i.sweep_addr < NW'(COLS);
  assign wb_row_ok  = wb_addr_q < NW'(ROWS);
  assign wb_col_ok  = wb_addr_q < NW'(COLS);

  assign st_o.action   = act_q;
  assign st_o.row_ok   = row_ok;
  assign st_o.trial_ok = trial_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beg_v_q      <= 1'b0;
      fin_v_q      <= 1'b0;
      read_valid_q <= 1'b0;
    end else begin
      beg_v_q      <= cmd_i.beg_rd;
      fin_v_q      <= cmd_i.fin_rd;
      read_valid_q <= cmd_i.rd_out;
    end
  end

  always_ff @(posedge clk_i) begin
    wb_addr_q <= cmd_i.sweep_addr;
    if (cmd_i.rd_out) begin
      out_sel_q <= {cost_rd_ok, row_ok};
    end
    if (cmd_i.mul_en) begin
      mul_q <= value_q * trial_rd_q;
    end
    if (cmd_i.rnd_en) begin
      addend_q <= (act_q == rhs_upd_pkg::ActRhsDelta) ? value_q : rhs_upd_pkg::round_sat(mul_q);
    end
  end

  assign acc_sum = (act_q == rhs_upd_pkg::ActBaseNz)
                 ? rhs_upd_pkg::sat_add(prod_rd_q, addend_q, 1'b0)
                 : rhs_upd_pkg::sat_add(rhs_work_rd_q, addend_q,
                                        act_q == rhs_upd_pkg::ActMatDelta);

  // rhs_base: loads write, the copy sweep reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_simple && act_q == rhs_upd_pkg::ActLoadRhs && row_ok) begin
      rhs_base_m[row_q[RAW-1:0]] <= value_q;
    end
    if (cmd_i.beg_rd && sw_row_ok) begin
      rhs_base_rd_q <= rhs_base_m[cmd_i.sweep_addr[RAW-1:0]];
    end
  end

  // rhs_work: one write port shared by the sweeps and the accumulate step.
  always_ff @(posedge clk_i) begin
    if (beg_v_q && wb_row_ok) begin
      rhs_work_m[wb_addr_q[RAW-1:0]] <= rhs_base_rd_q;
    end else if (fin_v_q) begin
      rhs_work_m[wb_addr_q[RAW-1:0]] <= rhs_upd_pkg::sat_add(rhs_work_rd_q, prod_rd_q, 1'b1);
    end else if (cmd_i.acc_wr && act_q != rhs_upd_pkg::ActBaseNz) begin
      rhs_work_m[row_q[RAW-1:0]] <= acc_sum;
    end
    if (cmd_i.fin_rd) begin
      rhs_work_rd_q <= rhs_work_m[cmd_i.sweep_addr[RAW-1:0]];
    end else if ((cmd_i.rd_rmw && act_q != rhs_upd_pkg::ActBaseNz)
                 || (cmd_i.rd_out && row_ok)) begin
      rhs_work_rd_q <= rhs_work_m[row_q[RAW-1:0]];
    end
  end

  // Product store: cleared by sweep, accumulated one entry at a time.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      prod_m[cmd_i.sweep_addr[RAW-1:0]] <= '0;
    end else if (cmd_i.acc_wr && act_q == rhs_upd_pkg::ActBaseNz) begin
      prod_m[row_q[RAW-1:0]] <= acc_sum;
    end
    if (cmd_i.fin_rd) begin
      prod_rd_q <= prod_m[cmd_i.sweep_addr[RAW-1:0]];
    end else if (cmd_i.rd_rmw && act_q == rhs_upd_pkg::ActBaseNz) begin
      prod_rd_q <= prod_m[row_q[RAW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_simple && act_q == rhs_upd_pkg::ActLoadCost && cost_ok) begin
      cost_base_m[col_q[CAW-1:0]] <= value_q;
    end
    if (cmd_i.beg_rd && sw_col_ok) begin
      cost_base_rd_q <= cost_base_m[cmd_i.sweep_addr[CAW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (beg_v_q && wb_col_ok) begin
      cost_work_m[wb_addr_q[CAW-1:0]] <= cost_base_rd_q;
    end else if (cmd_i.wr_simple && act_q == rhs_upd_pkg::ActCostDelta && cost_ok) begin
      cost_work_m[col_q[CAW-1:0]] <= value_q;
    end
    if (cmd_i.rd_out && cost_rd_ok) begin
      cost_work_rd_q <= cost_work_m[cost_k[CAW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_simple && act_q == rhs_upd_pkg::ActLoadTrial && trial_ok) begin
      trial_m[col_q[TAW-1:0]] <= value_q;
    end
    if (cmd_i.rd_rmw && trial_ok) begin
      trial_rd_q <= trial_m[col_q[TAW-1:0]];
    end
  end

  assign read_valid_o = read_valid_q;
  assign read_value_o = out_sel_q[0] ? rhs_work_rd_q
                      : (out_sel_q[1] ? cost_work_rd_q : '0);

endmodule

@@ src/scenario_rhs_sparse_update.sv @@
// Top level of the scenario right-hand-side builder: controller plus datapath.
`timescale 1ns / 1ps
// Channel   Direction  Ports                                              Transfer when
// command   in         action_i, row_index_i, col_index_i, value_i       start high, busy low
// result    out        read_value_o                                       read_valid_o high
//
// Loads, the cost delta and reads pass through the execute state; a read result
// appears in the cycle after it, while the next command may already be taken.
// Base nonzero and matrix delta step through read, multiply, round and add;
// the rhs delta skips the multiply. There is a single multiplier path.
// Clear and finish sweep ROWS memory entries and begin max(ROWS,COLS), one
// entry per cycle. After reset the product store is cleared, all ROWS entries,
// with busy high. The receiver cannot stall: each result is shown for one cycle.
module scenario_rhs_sparse_update #(
  parameter int unsigned ROWS       = 1024,
  parameter int unsigned COLS       = 1024,
  parameter int unsigned FIRST_COLS = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [rhs_upd_pkg::ActW-1:0]         action_i,
  input  logic [rhs_upd_pkg::RowW-1:0]         row_index_i,
  input  logic [rhs_upd_pkg::ColW-1:0]         col_index_i,
  input  logic signed [rhs_upd_pkg::DataW-1:0] value_i,
  output logic                                 read_valid_o,
  output logic signed [rhs_upd_pkg::DataW-1:0] read_value_o
);

  localparam int unsigned SweepN = (ROWS > COLS) ? ROWS : COLS;

  rhs_upd_pkg::cmd_t    cmd;
  rhs_upd_pkg::status_t st;

  // The controller owns the handshake and all sequencing.
  rhs_upd_ctrl #(
    .ROWS    (ROWS),
    .SWEEP_N (SweepN)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  // The datapath holds the vectors and does all arithmetic.
  rhs_upd_dp #(
    .ROWS       (ROWS),
    .COLS       (COLS),
    .FIRST_COLS (FIRST_COLS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .action_i     (action_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .st_o         (st),
    .read_valid_o (read_valid_o),
    .read_value_o (read_value_o)
  );

  // An accepted command always occupies the block for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  // A result only follows a cycle in which a command was being executed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_valid_o |-> $past(busy))
    else $error("result strobe without a command in flight");

  // Results never come in consecutive cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_valid_o |=> !read_valid_o)
    else $error("result strobe held for more than one cycle");

endmodule
